[src/plc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants and control types for the positional circular list.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CMD_W = 3;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int OCC_W = 5;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TRAVERSE  = 3'd6;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd3;
  localparam logic [ST_W-1:0] ST_SINGLE = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic setup;
    logic up_step;
    logic put;
    logic fetch;
    logic capture;
    logic dn_step;
    logic t_read;
    logic t_load;
    logic reply;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ins;
    logic del;
    logic trav;
    logic up_done;
    logic dn_done;
    logic last;
  } dp_flags_t;

endpackage

[src/plc_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_in_if
// Command channel: valid/ready with command, position and value.
// ----------------------------------------------------------------------------
interface plc_in_if;
  logic                                valid;
  logic                                ready;
  logic        [plc_pkg::CMD_W-1:0]    command;
  logic        [plc_pkg::POS_W-1:0]    position;
  logic signed [plc_pkg::VAL_W-1:0]    item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);
endinterface

[src/plc_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_out_if
// Result channel: valid/ready with value, status, occupancy and last flag.
// ----------------------------------------------------------------------------
interface plc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plc_pkg::VAL_W-1:0]    out_value;
  logic        [plc_pkg::ST_W-1:0]     status;
  logic        [plc_pkg::OCC_W-1:0]    occupancy;
  logic                                last;

  modport source (output valid, out_value, status, occupancy, last, input ready);
  modport sink   (input valid, out_value, status, occupancy, last, output ready);
endinterface

[src/plc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plc_ram #(
  parameter int WIDTH = plc_pkg::VAL_W,
  parameter int DEPTH = plc_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/plc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_datapath
// Element store, count, shift pointer, command checks and result register.
// ----------------------------------------------------------------------------
module plc_datapath #(
  parameter int DEPTH = plc_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  plc_pkg::dp_ctl_t                 ctl,
  output plc_pkg::dp_flags_t               flags,
  input  logic        [plc_pkg::CMD_W-1:0] command,
  input  logic        [plc_pkg::POS_W-1:0] position,
  input  logic signed [plc_pkg::VAL_W-1:0] item_value,
  output logic signed [plc_pkg::VAL_W-1:0] out_value,
  output logic        [plc_pkg::ST_W-1:0]  status,
  output logic        [plc_pkg::OCC_W-1:0] occupancy,
  output logic                             last
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W) + 1;

  // Latched command.
  logic [plc_pkg::CMD_W-1:0] op;
  logic [plc_pkg::POS_W-1:0] pos;
  logic [plc_pkg::VAL_W-1:0] item;

  logic [CW-1:0]             cnt;
  logic [CW-1:0]             cnt_next;
  logic [AW-1:0]             ptr;
  logic [AW-1:0]             tgt;
  logic [AW-1:0]             wa;
  logic                      pend;
  logic [plc_pkg::ST_W-1:0]  res_st;
  logic                      ins_ok;
  logic                      del_ok;
  logic [plc_pkg::VAL_W-1:0] del_val;

  logic [plc_pkg::ST_W-1:0]  dec_st;
  logic                      dec_ins;
  logic                      dec_del;
  logic                      dec_trav;
  logic [AW-1:0]             dec_idx;
  logic [CMPW-1:0]           posx;
  logic [CMPW-1:0]           cntx;
  logic                      full;
  logic                      at_end;
  logic                      up_go;
  logic                      dn_go;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [plc_pkg::VAL_W-1:0] wdata;
  logic                      re;
  logic [AW-1:0]             raddr;
  logic [plc_pkg::VAL_W-1:0] rdata;

  assign posx   = CMPW'(pos);
  assign cntx   = CMPW'(cnt);
  assign full   = (cnt == CW'(DEPTH));
  assign at_end = ((CW'(ptr) + CW'(1)) >= cnt);
  assign up_go  = ctl.up_step && (ptr != tgt);
  assign dn_go  = ctl.dn_step && !at_end;

  always_comb begin
    dec_st   = plc_pkg::ST_OK;
    dec_ins  = 1'b0;
    dec_del  = 1'b0;
    dec_trav = 1'b0;
    dec_idx  = '0;
    case (op)
      plc_pkg::CMD_INS_FRONT, plc_pkg::CMD_INS_REAR: begin
        if (full) begin
          dec_st = plc_pkg::ST_FULL;
        end else begin
          dec_ins = 1'b1;
          dec_idx = (op == plc_pkg::CMD_INS_FRONT) ? '0 : AW'(cnt);
        end
      end
      plc_pkg::CMD_INS_POS: begin
        if (cnt == '0) begin
          dec_st = plc_pkg::ST_EMPTY;
        end else if (full) begin
          dec_st = plc_pkg::ST_FULL;
        end else if (posx == '0 || posx > cntx + CMPW'(1)) begin
          dec_st = plc_pkg::ST_RANGE;
        end else begin
          dec_ins = 1'b1;
          dec_idx = AW'(posx - CMPW'(1));
        end
      end
      plc_pkg::CMD_DEL_FRONT, plc_pkg::CMD_DEL_REAR: begin
        if (cnt == '0) begin
          dec_st = plc_pkg::ST_EMPTY;
        end else begin
          dec_del = 1'b1;
          dec_idx = (op == plc_pkg::CMD_DEL_FRONT) ? '0 : AW'(cnt - CW'(1));
        end
      end
      plc_pkg::CMD_DEL_POS: begin
        if (cnt == '0) begin
          dec_st = plc_pkg::ST_EMPTY;
        end else if (cnt == CW'(1)) begin
          dec_st = plc_pkg::ST_SINGLE;
        end else if (posx == '0 || posx > cntx) begin
          dec_st = plc_pkg::ST_RANGE;
        end else begin
          dec_del = 1'b1;
          dec_idx = AW'(posx - CMPW'(1));
        end
      end
      plc_pkg::CMD_TRAVERSE: begin
        if (cnt == '0) begin
          dec_st = plc_pkg::ST_EMPTY;
        end else begin
          dec_trav = 1'b1;
        end
      end
      default: begin
        dec_st = plc_pkg::ST_OK;
      end
    endcase
  end

  // One read and one write per cycle. A shift read issued in one cycle is
  // written back one slot over in the next cycle.
  always_comb begin
    re    = 1'b0;
    raddr = ptr;
    if (up_go) begin
      re    = 1'b1;
      raddr = ptr - AW'(1);
    end else if (dn_go) begin
      re    = 1'b1;
      raddr = ptr + AW'(1);
    end else if (ctl.fetch) begin
      re    = 1'b1;
      raddr = tgt;
    end else if (ctl.t_read) begin
      re    = 1'b1;
      raddr = ptr;
    end
    we    = pend || ctl.put;
    waddr = pend ? wa : tgt;
    wdata = pend ? rdata : item;
  end

  always_comb begin
    if (ins_ok) begin
      cnt_next = cnt + CW'(1);
    end else if (del_ok) begin
      cnt_next = cnt - CW'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= up_go || dn_go;
      if (ctl.reply) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      op   <= command;
      pos  <= position;
      item <= item_value;
    end
    if (ctl.setup) begin
      res_st <= dec_st;
      ins_ok <= dec_ins;
      del_ok <= dec_del;
      tgt    <= dec_idx;
      ptr    <= dec_ins ? AW'(cnt) : dec_idx;
    end
    if (up_go) begin
      wa  <= ptr;
      ptr <= ptr - AW'(1);
    end
    if (dn_go) begin
      wa  <= ptr;
      ptr <= ptr + AW'(1);
    end
    if (ctl.capture) begin
      del_val <= rdata;
    end
    if (ctl.t_load) begin
      out_value <= rdata;
      status    <= plc_pkg::ST_OK;
      occupancy <= plc_pkg::OCC_W'(cnt);
      last      <= flags.last;
      ptr       <= ptr + AW'(1);
    end
    if (ctl.reply) begin
      out_value <= del_ok ? del_val : '0;
      status    <= res_st;
      occupancy <= plc_pkg::OCC_W'(cnt_next);
      last      <= 1'b1;
    end
  end

  assign flags.ins     = dec_ins;
  assign flags.del     = dec_del;
  assign flags.trav    = dec_trav;
  assign flags.up_done = (ptr == tgt) && !pend;
  assign flags.dn_done = at_end && !pend;
  assign flags.last    = ((CW'(ptr) + CW'(1)) == cnt);

  plc_ram #(
    .WIDTH (plc_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

[src/plc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_ctrl
// Sequencer for one command: check, shift, write or read, then reply; a traverse loads one result per element instead.
// ----------------------------------------------------------------------------
module plc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output plc_pkg::dp_ctl_t   ctl,
  input  plc_pkg::dp_flags_t flags
);

  typedef enum logic [3:0] {
    IDLE,
    DECODE,
    SHIFT_UP,
    PUT,
    FETCH,
    CAPTURE,
    SHIFT_DN,
    T_RD,
    T_WAIT,
    REPLY
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   load;

  assign in_ready  = (state == IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    load       = 1'b0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          ctl.take   = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        ctl.setup = 1'b1;
        if (flags.ins) begin
          state_next = SHIFT_UP;
        end else if (flags.del) begin
          state_next = FETCH;
        end else if (flags.trav) begin
          state_next = T_RD;
        end else begin
          state_next = REPLY;
        end
      end
      SHIFT_UP: begin
        ctl.up_step = 1'b1;
        if (flags.up_done) begin
          state_next = PUT;
        end
      end
      PUT: begin
        ctl.put    = 1'b1;
        state_next = REPLY;
      end
      FETCH: begin
        ctl.fetch  = 1'b1;
        state_next = CAPTURE;
      end
      CAPTURE: begin
        ctl.capture = 1'b1;
        state_next  = SHIFT_DN;
      end
      SHIFT_DN: begin
        ctl.dn_step = 1'b1;
        if (flags.dn_done) begin
          state_next = REPLY;
        end
      end
      T_RD: begin
        ctl.t_read = 1'b1;
        state_next = T_WAIT;
      end
      T_WAIT: begin
        if (slot_free) begin
          ctl.t_load = 1'b1;
          load       = 1'b1;
          state_next = flags.last ? IDLE : T_RD;
        end
      end
      REPLY: begin
        if (slot_free) begin
          ctl.reply  = 1'b1;
          load       = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/positional_circular_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_circular_list_top
// Ordered list of signed values with insert, delete and traverse commands.
// ----------------------------------------------------------------------------
//   port  dir  transfer carries
//   req   in   command, position, item_value
//   rsp   out  out_value, status, occupancy, last
//
// A refused or unused command goes from the check straight to its reply.
// An insert shifts the elements from its slot on up by one, then writes
// its value and replies; a delete keeps its element, shifts the later ones
// down, lets the last write-back finish and replies. A traverse reads each
// element through the registered RAM read and loads one result per element.
// The next command is taken once the final result is loaded. Reset clears
// the count, the sequencer state and the result valid; the RAM needs no
// clearing. A stalled result holds in the output register and stalls the
// sequencer only when it has the next result ready.
module positional_circular_list_top #(
  parameter int DEPTH = plc_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  plc_in_if.sink    req,
  plc_out_if.source rsp
);

  plc_pkg::dp_ctl_t   ctl;
  plc_pkg::dp_flags_t flags;

  plc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl),
    .flags     (flags)
  );

  plc_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .flags      (flags),
    .command    (req.command),
    .position   (req.position),
    .item_value (req.item_value),
    .out_value  (rsp.out_value),
    .status     (rsp.status),
    .occupancy  (rsp.occupancy),
    .last       (rsp.last)
  );

endmodule
